@@ rtl/core/lpht_pkg.sv @@
// lpht_pkg: shared constants for the linear probing hash table
// slot geometry, field widths, result status codes and action codes; no dependencies
`timescale 1ns / 1ps

package lpht_pkg;

  // slot count must be a power of two: the start slot is the low hash bits
  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int HASH_W  = 32;
  localparam int COUNT_W = 11;
  localparam int ENTRY_W = KEY_W + VAL_W;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_MISS = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_ZERO = 2'd3;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

endpackage

@@ rtl/core/linear_probe_hash_table_unit.sv @@
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// probe sequencer around lpht_ram (key and value per entry); uses lpht_pkg
// probe run: reads 1..SLOTS slots, one ram read per slot probed; a zero
//   key gives its result in the cycle after the accepting edge, with no read
// requests: a new one is taken only in idle, once the previous run has ended
// reset: after rst_n the key store is cleared, one slot a cycle, over all
//   SLOTS (1024) with busy high; results cannot be stalled by the receiver
`timescale 1ns / 1ps

module linear_probe_hash_table_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_action,
  input  logic [lpht_pkg::KEY_W-1:0]     in_key,
  input  logic [lpht_pkg::HASH_W-1:0]    in_hash,
  input  logic [lpht_pkg::VAL_W-1:0]     in_value,
  output logic                           out_valid,
  output lpht_pkg::status_t              out_status,
  output logic [lpht_pkg::VAL_W-1:0]     out_value_out,
  output logic [lpht_pkg::COUNT_W-1:0]   out_count
);

  localparam logic [1:0] S_CLR   = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  localparam logic [lpht_pkg::IDX_W-1:0] LAST_IDX = lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1);

  logic [1:0]                       state_r, state_nxt;
  logic [lpht_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [lpht_pkg::IDX_W-1:0]       n_r, n_nxt;
  logic [lpht_pkg::COUNT_W-1:0]     occ_r, occ_nxt;
  logic                             act_r, act_nxt;
  logic [lpht_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [lpht_pkg::VAL_W-1:0]       val_r, val_nxt;

  logic                             out_valid_r, out_valid_nxt;
  lpht_pkg::status_t                out_status_r, out_status_nxt;
  logic [lpht_pkg::VAL_W-1:0]       out_value_r, out_value_nxt;

  logic                             ram_we, ram_re;
  logic [lpht_pkg::IDX_W-1:0]       ram_waddr, ram_raddr;
  logic [lpht_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
  logic [lpht_pkg::KEY_W-1:0]       rd_key;
  logic [lpht_pkg::VAL_W-1:0]       rd_val;

  lpht_ram #(
    .DEPTH (lpht_pkg::SLOTS),
    .WIDTH (lpht_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[lpht_pkg::ENTRY_W-1:lpht_pkg::VAL_W];
  assign rd_val = ram_rdata[lpht_pkg::VAL_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    occ_nxt        = occ_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = {key_r, val_r};
    ram_re         = 1'b0;
    ram_raddr      = idx_r + 1'b1;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_raddr = in_hash[lpht_pkg::IDX_W-1:0];
        if (start) begin
          if (in_key == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = lpht_pkg::ST_ZERO;
            out_value_nxt  = '0;
          end else begin
            ram_re    = 1'b1;
            idx_nxt   = in_hash[lpht_pkg::IDX_W-1:0];
            n_nxt     = '0;
            act_nxt   = in_action;
            key_nxt   = in_key;
            val_nxt   = in_value;
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        out_value_nxt = '0;
        priority if (rd_key == '0) begin
          // empty slot ends both a put and a get
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (act_r == lpht_pkg::ACT_PUT) begin
            ram_we         = 1'b1;
            occ_nxt        = occ_r + 1'b1;
            out_status_nxt = lpht_pkg::ST_OK;
          end else begin
            out_status_nxt = lpht_pkg::ST_MISS;
          end
        end else if (act_r == lpht_pkg::ACT_GET && rd_key == key_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = lpht_pkg::ST_OK;
          out_value_nxt  = rd_val;
          state_nxt      = S_IDLE;
        end else if (n_r == LAST_IDX) begin
          // full lap without a hit
          out_valid_nxt  = 1'b1;
          out_status_nxt = (act_r == lpht_pkg::ACT_PUT) ? lpht_pkg::ST_FULL
                                                        : lpht_pkg::ST_MISS;
          state_nxt      = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          n_nxt   = n_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;
  assign out_count     = occ_r;

  // no result while the key store is being cleared
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid_r)
    else $error("result strobe during clearing pass");

  // occupancy moves only on a put that lands in an empty slot
  a_occ_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (!(state_r == S_PROBE && ram_we)) |=> (occ_r == $past(occ_r)))
    else $error("occupancy changed without a put transaction");

  // a probe run writes the table only for a put
  a_write_only_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && ram_we) |-> (act_r == lpht_pkg::ACT_PUT))
    else $error("table write during a get transaction");

  // only a found get carries a value
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != lpht_pkg::ST_OK) |-> (out_value_r == '0))
    else $error("nonzero value on a failed transaction");

  // an empty slot always terminates the probe run
  a_empty_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && rd_key == '0) |=> (state_r == S_IDLE && out_valid_r))
    else $error("probe run continued past an empty slot");

endmodule

@@ rtl/core/lpht_ram.sv @@
// lpht_ram: generic simple dual-port synchronous ram
// one write port, one read port with registered read data; no dependencies
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
